[hdl/simon_block_cipher_unit_defines.svh]
// assertion macros for the port-level checker
`ifndef SIMON_BLOCK_CIPHER_UNIT_DEFINES_SVH
`define SIMON_BLOCK_CIPHER_UNIT_DEFINES_SVH

// same-cycle implication, held off while reset is asserted
`define SIMON_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("simon check failed");

// next-cycle implication, held off while reset is asserted
`define SIMON_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("simon check failed");

`endif

[hdl/simon_pkg.sv]
// shared types, constants and round functions of the simon 64/128 unit
`default_nettype none

package simon_pkg;

    localparam int WORD_W = 32;
    localparam int RC_W = 6;
    localparam int CFG_IDX_W = 3;
    localparam int KEY_WORDS = 4;
    localparam int Z_SEQUENCE = 3;
    localparam int Z_LEN = 62;
    localparam int Z_IDX_W = 6;

    // register indexes of the write port
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_COUNT = 3'd4;

    localparam logic [RC_W-1:0] ROUND_COUNT_RESET = 6'd44;

    // z sequences, bit 0 is the first element
    localparam logic [0:Z_LEN-1] Z2_SEQ =
        62'b10101111011100000011010010011000101000010001111110010110110011;
    localparam logic [0:Z_LEN-1] Z3_SEQ =
        62'b11011011101011000110010111100000010010001010011100110100001111;

    localparam logic [WORD_W-1:0] ROUND_CONST = 32'd3;

    typedef logic [3:0][WORD_W-1:0] key_words_t;

    typedef struct packed {
        logic              action;
        logic [WORD_W-1:0] block_x;
        logic [WORD_W-1:0] block_y;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] result_x;
        logic [WORD_W-1:0] result_y;
    } out_item_t;

    typedef enum logic {
        ENG_IDLE,
        ENG_RUN
    } eng_state_t;

    function automatic logic [WORD_W-1:0] rotr3(input logic [WORD_W-1:0] v);
        rotr3 = {v[2:0], v[WORD_W-1:3]};
    endfunction

    function automatic logic [WORD_W-1:0] rotr1(input logic [WORD_W-1:0] v);
        rotr1 = {v[0], v[WORD_W-1:1]};
    endfunction

    // f(v) = (v <<< 1 & v <<< 8) ^ v <<< 2
    function automatic logic [WORD_W-1:0] feistel(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] r1;
        logic [WORD_W-1:0] r2;
        logic [WORD_W-1:0] r8;
        r1 = {v[WORD_W-2:0], v[WORD_W-1]};
        r2 = {v[WORD_W-3:0], v[WORD_W-1:WORD_W-2]};
        r8 = {v[WORD_W-9:0], v[WORD_W-1:WORD_W-8]};
        feistel = (r1 & r8) ^ r2;
    endfunction

    function automatic logic z_bit(input logic [Z_IDX_W-1:0] idx);
        if (Z_SEQUENCE == 2)
        begin
            z_bit = Z2_SEQ[idx];
        end
        else
        begin
            z_bit = Z3_SEQ[idx];
        end
    endfunction

endpackage

`default_nettype wire

[hdl/simon_block_cipher_unit.sv]
// top level of the simon 64/128 block cipher unit
//
//  channel   handshake            payload                    notes
//  --------  -------------------  -------------------------  --------------------------
//  item in   start, busy          request (in_item_t)        taken when start && !busy
//  item out  done                 result (out_item_t)        one-cycle strobe, no stall
//  config    cfg_we               cfg_index, cfg_data        written on any cfg_we edge
//
//  an item with N = min(round_count, MAX_ROUNDS) rounds runs them from accept to done,
//  one round per cycle paced by the single read port of the key store
//  zero rounds gives done in the cycle after accept with the block unchanged
//  after reset and after every key word write the schedule is rebuilt with busy high,
//  one key per cycle into every entry of the key store
//  a new item may be started in the same cycle that done shows the previous one
`default_nettype none

module simon_block_cipher_unit #(
    parameter int MAX_ROUNDS = 44
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire simon_pkg::in_item_t                request,
    output logic                                    done,
    output simon_pkg::out_item_t                    result,
    input  wire logic                               cfg_we,
    input  wire logic [simon_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [simon_pkg::WORD_W-1:0]       cfg_data
);

    localparam int ADDR_W = $clog2(MAX_ROUNDS);
    localparam int CNT_W  = $clog2(MAX_ROUNDS + 1);
    localparam int CMP_W  = (CNT_W > simon_pkg::RC_W) ? CNT_W : simon_pkg::RC_W;

    simon_pkg::key_words_t          key_reg;
    logic [simon_pkg::RC_W-1:0]     round_count_reg;
    logic                           key_write;
    logic [CMP_W-1:0]               rc_cmp;
    logic [CNT_W-1:0]               n_rounds;
    logic                           accept;
    logic                           expanding;
    logic                           running;
    logic                           wr_en;
    logic [ADDR_W-1:0]              wr_addr;
    logic [simon_pkg::WORD_W-1:0]   wr_data;
    logic                           rd_en;
    logic [ADDR_W-1:0]              rd_addr;
    logic [simon_pkg::WORD_W-1:0]   rd_data;

    // only key words change the schedule, the round count is read per item
    assign key_write = cfg_we && (cfg_index == simon_pkg::REG_KEY_WORD0 ||
                                  cfg_index == simon_pkg::REG_KEY_WORD1 ||
                                  cfg_index == simon_pkg::REG_KEY_WORD2 ||
                                  cfg_index == simon_pkg::REG_KEY_WORD3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg         <= '0;
            round_count_reg <= simon_pkg::ROUND_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                simon_pkg::REG_KEY_WORD0: key_reg[0] <= cfg_data;
                simon_pkg::REG_KEY_WORD1: key_reg[1] <= cfg_data;
                simon_pkg::REG_KEY_WORD2: key_reg[2] <= cfg_data;
                simon_pkg::REG_KEY_WORD3: key_reg[3] <= cfg_data;
                simon_pkg::REG_ROUND_COUNT:
                begin
                    round_count_reg <= cfg_data[simon_pkg::RC_W-1:0];
                end
                default:
                begin
                    // indexes past the list are dropped
                    round_count_reg <= round_count_reg;
                end
            endcase
        end
    end

    // round count saturates at the depth of the key store
    assign rc_cmp   = CMP_W'(round_count_reg);
    assign n_rounds = (rc_cmp > CMP_W'(MAX_ROUNDS)) ? CNT_W'(MAX_ROUNDS) : CNT_W'(rc_cmp);

    assign busy   = expanding || running;
    assign accept = start && !busy;

    simon_key_expand #(
        .MAX_ROUNDS (MAX_ROUNDS),
        .ADDR_W     (ADDR_W)
    ) u_expand (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (key_write),
        .key_words (key_reg),
        .active    (expanding),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    simon_key_ram #(
        .DEPTH  (MAX_ROUNDS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // busy blocks starts; the user must keep engine reads off a schedule being written
    simon_round_engine #(
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .request  (request),
        .n_rounds (n_rounds),
        .rd_data  (rd_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .running  (running),
        .done     (done),
        .result   (result)
    );

endmodule

`default_nettype wire

[hdl/simon_key_ram.sv]
// round key store, one write port and one registered read port
`default_nettype none

module simon_key_ram #(
    parameter int DEPTH  = 44,
    parameter int ADDR_W = 6
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [ADDR_W-1:0]             wr_addr,
    input  wire logic [simon_pkg::WORD_W-1:0]  wr_data,
    input  wire logic                          rd_en,
    input  wire logic [ADDR_W-1:0]             rd_addr,
    output logic      [simon_pkg::WORD_W-1:0]  rd_data
);

    logic [simon_pkg::WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[hdl/simon_key_expand.sv]
// key schedule sequencer, writes one round key per cycle into the store
`default_nettype none

module simon_key_expand #(
    parameter int MAX_ROUNDS = 44,
    parameter int ADDR_W     = 6
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          restart,
    input  wire simon_pkg::key_words_t         key_words,
    output logic                               active,
    output logic                               wr_en,
    output logic      [ADDR_W-1:0]             wr_addr,
    output logic      [simon_pkg::WORD_W-1:0]  wr_data
);

    logic                                  active_reg;
    logic                                  active_next;
    logic [ADDR_W-1:0]                     idx_reg;
    logic [ADDR_W-1:0]                     idx_next;
    logic [simon_pkg::Z_IDX_W-1:0]         zidx_reg;
    logic [simon_pkg::Z_IDX_W-1:0]         zidx_next;
    simon_pkg::key_words_t                 win_reg;
    simon_pkg::key_words_t                 win_next;
    logic [simon_pkg::WORD_W-1:0]          tmp_a;
    logic [simon_pkg::WORD_W-1:0]          tmp_b;
    logic [simon_pkg::WORD_W-1:0]          key;
    logic                                  from_cfg;
    logic                                  last;

    // compared at full width so a narrow index still sees every key word
    assign from_cfg = 32'(idx_reg) < 32'(simon_pkg::KEY_WORDS);
    assign last     = idx_reg == ADDR_W'(MAX_ROUNDS - 1);

    // win_reg[0] holds the key one place back
    always_comb
    begin
        tmp_a = simon_pkg::rotr3(win_reg[0]);
        if (simon_pkg::KEY_WORDS == 4)
        begin
            tmp_a = tmp_a ^ win_reg[2];
        end
        tmp_b = tmp_a ^ simon_pkg::rotr1(tmp_a);
        if (from_cfg)
        begin
            key = key_words[idx_reg[1:0]];
        end
        else
        begin
            key = ~win_reg[simon_pkg::KEY_WORDS-1] ^ tmp_b ^ simon_pkg::ROUND_CONST ^
                  {{(simon_pkg::WORD_W-1){1'b0}}, simon_pkg::z_bit(zidx_reg)};
        end
    end

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        zidx_next   = zidx_reg;
        win_next    = win_reg;
        if (restart)
        begin
            active_next = 1'b1;
            idx_next    = '0;
            zidx_next   = '0;
        end
        else if (active_reg)
        begin
            win_next = {win_reg[2:0], key};
            idx_next = idx_reg + 1'b1;
            if (last)
            begin
                active_next = 1'b0;
            end
            if (!from_cfg)
            begin
                if (zidx_reg == simon_pkg::Z_IDX_W'(simon_pkg::Z_LEN - 1))
                begin
                    zidx_next = '0;
                end
                else
                begin
                    zidx_next = zidx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            idx_reg    <= '0;
            zidx_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
            zidx_reg   <= zidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    assign active  = active_reg;
    assign wr_en   = active_reg && !restart;
    assign wr_addr = idx_reg;
    assign wr_data = key;

endmodule

`default_nettype wire

[hdl/simon_round_engine.sv]
// round sequencer and feistel datapath, one round per cycle
`default_nettype none

module simon_round_engine #(
    parameter int ADDR_W = 6,
    parameter int CNT_W  = 6
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire simon_pkg::in_item_t           request,
    input  wire logic [CNT_W-1:0]              n_rounds,
    input  wire logic [simon_pkg::WORD_W-1:0]  rd_data,
    output logic                               rd_en,
    output logic      [ADDR_W-1:0]             rd_addr,
    output logic                               running,
    output logic                               done,
    output simon_pkg::out_item_t               result
);

    simon_pkg::eng_state_t          state_reg;
    simon_pkg::eng_state_t          state_next;
    logic [CNT_W-1:0]               cnt_reg;
    logic [ADDR_W-1:0]              ptr_reg;
    logic [ADDR_W-1:0]              start_addr;
    logic                           dec_reg;
    logic [simon_pkg::WORD_W-1:0]   x_reg;
    logic [simon_pkg::WORD_W-1:0]   y_reg;
    logic [simon_pkg::WORD_W-1:0]   x_rnd;
    logic [simon_pkg::WORD_W-1:0]   y_rnd;
    logic                           done_reg;
    simon_pkg::out_item_t           result_reg;
    logic                           last;

    assign last = cnt_reg == CNT_W'(1);

    // decrypt walks the keys from the top down
    assign start_addr = request.action ? ADDR_W'(n_rounds - 1'b1) : '0;

    always_comb
    begin
        if (dec_reg)
        begin
            x_rnd = y_reg;
            y_rnd = x_reg ^ simon_pkg::feistel(y_reg) ^ rd_data;
        end
        else
        begin
            x_rnd = y_reg ^ simon_pkg::feistel(x_reg) ^ rd_data;
            y_rnd = x_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            simon_pkg::ENG_IDLE:
            begin
                if (accept && n_rounds != '0)
                begin
                    state_next = simon_pkg::ENG_RUN;
                end
            end
            simon_pkg::ENG_RUN:
            begin
                if (last)
                begin
                    state_next = simon_pkg::ENG_IDLE;
                end
            end
            default:
            begin
                state_next = simon_pkg::ENG_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = ptr_reg;
        running = 1'b0;
        case (state_reg)
            simon_pkg::ENG_IDLE:
            begin
                rd_en   = accept;
                rd_addr = start_addr;
            end
            simon_pkg::ENG_RUN:
            begin
                rd_en   = !last;
                running = 1'b1;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= simon_pkg::ENG_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (state_reg == simon_pkg::ENG_IDLE && accept)
            begin
                cnt_reg  <= n_rounds;
                done_reg <= n_rounds == '0;
            end
            else if (state_reg == simon_pkg::ENG_RUN)
            begin
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == simon_pkg::ENG_IDLE && accept)
        begin
            x_reg   <= request.block_x;
            y_reg   <= request.block_y;
            dec_reg <= request.action;
            ptr_reg <= request.action ? start_addr - 1'b1 : start_addr + 1'b1;
            // zero rounds hands the block back unchanged
            result_reg.result_x <= request.block_x;
            result_reg.result_y <= request.block_y;
        end
        else if (state_reg == simon_pkg::ENG_RUN)
        begin
            x_reg   <= x_rnd;
            y_reg   <= y_rnd;
            ptr_reg <= dec_reg ? ptr_reg - 1'b1 : ptr_reg + 1'b1;
            if (last)
            begin
                result_reg.result_x <= x_rnd;
                result_reg.result_y <= y_rnd;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[hdl/simon_chk.sv]
// port-level checker for the simon unit and its bind
`default_nettype none

`include "simon_block_cipher_unit_defines.svh"

module simon_chk (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic                               busy,
    input  wire logic                               done,
    input  wire logic                               cfg_we,
    input  wire logic [simon_pkg::CFG_IDX_W-1:0]    cfg_index
);

    // a result only follows an accepted item or a running one
    `SIMON_ASSERT_IMP(a_done_has_cause, clk, rst_n, done, $past(start && !busy) || $past(busy))

    // an accepted item either finishes at once or keeps the unit busy
    `SIMON_ASSERT_NXT(a_accept_then_work, clk, rst_n, start && !busy, busy || done)

    // a key word write rebuilds the schedule and holds items off
    `SIMON_ASSERT_NXT(a_key_write_busy, clk, rst_n,
        cfg_we && cfg_index < simon_pkg::REG_ROUND_COUNT, busy)

endmodule

bind simon_block_cipher_unit simon_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index)
);

`default_nettype wire
